// ===== hdl/fpa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: action and status codes,
// the per-item side record and the saturation helper.
// No dependencies.
package fpa_pkg;

   typedef enum logic [3:0] {
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_GT, ACT_LT, ACT_GE, ACT_LE,
      ACT_EQ, ACT_NE, ACT_INC, ACT_DEC, ACT_MIN, ACT_MAX, ACT_FROM_INT, ACT_TO_INT
   } fpa_action_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } fpa_status_type;

   // Result fields that travel beside the divider data.
   typedef struct packed {
      logic           is_div;
      logic           neg;
      logic [31:0]    value;
      logic           cmp;
      fpa_status_type status;
   } fpa_side_type;

   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

   // Clamp a wide signed value to 32 bits; the top bit of the result flags overflow.
   function automatic logic [32:0] fpa_sat(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > S32_MAX) begin
         r = {1'b1, S32_MAX[31:0]};
      end else if (v < S32_MIN) begin
         r = {1'b1, S32_MIN[31:0]};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== hdl/fixed_point_q24_8_alu.sv =====
// Signed fixed-point ALU, pipelined: every action passes through the decode register, the
// multiply rounding register, the chain of one-bit division cells and the output register.
// Throughput is one item per cycle; the whole pipeline stalls while a result waits.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
// Depends on fpa_pkg, fpa_front and fpa_div_cell.
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  logic [3:0]  req_tuser,   // action[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result_value[31:0], compare_true[32], status[34:33], pad
);
   import fpa_pkg::*;

   localparam int NB = 32 + FRAC_BITS;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Decode stage.
   fpa_side_type  f_side;
   logic [NB-1:0] f_num;
   logic [31:0]   f_den;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .action    (fpa_action_type'(req_tuser)),
      .operand_a (req_tdata[31:0]),
      .operand_b (req_tdata[63:32]),
      .side      (f_side),
      .num       (f_num),
      .den       (f_den)
   );

   logic               s1_valid_ff;
   logic               s1_mul_ff;
   logic signed [63:0] s1_prod_ff;
   fpa_side_type       s1_side_ff;
   logic [NB-1:0]      s1_num_ff;
   logic [31:0]        s1_den_ff;
   logic signed [31:0] op_a, op_b;

   assign op_a = req_tdata[31:0];
   assign op_b = req_tdata[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s1_mul_ff  <= fpa_action_type'(req_tuser) == ACT_MUL;
         s1_prod_ff <= op_a * op_b;
         s1_side_ff <= f_side;
         s1_num_ff  <= f_num;
         s1_den_ff  <= f_den;
      end
   end

   // Multiply rounding stage: half away from zero, then saturate.
   logic [63:0]        mag;
   logic [63:0]        rnd;
   logic signed [63:0] mres;
   logic [32:0]        msat;
   fpa_side_type       s2_side;

   always_comb begin
      mag  = s1_prod_ff[63] ? 64'(-s1_prod_ff) : 64'(s1_prod_ff);
      rnd  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      mres = s1_prod_ff[63] ? -$signed(rnd) : $signed(rnd);
      msat = fpa_sat(mres);
      s2_side = s1_side_ff;
      if (s1_mul_ff) begin
         s2_side.value  = msat[31:0];
         s2_side.status = msat[32] ? ST_OVF : ST_OK;
      end
   end

   logic               s2_valid_ff;
   fpa_side_type       s2_side_ff;
   logic [NB-1:0]      s2_num_ff;
   logic [31:0]        s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_side_ff <= s2_side;
         s2_num_ff  <= s1_num_ff;
         s2_den_ff  <= s1_den_ff;
      end
   end

   // Division chain, one quotient bit per cell.
   logic          c_valid [NB+1];
   logic [31:0]   c_rem   [NB+1];
   logic [NB-1:0] c_num   [NB+1];
   logic [NB-1:0] c_quo   [NB+1];
   logic [31:0]   c_den   [NB+1];
   fpa_side_type  c_side  [NB+1];

   assign c_valid[0] = s2_valid_ff;
   assign c_rem[0]   = '0;
   assign c_num[0]   = s2_num_ff;
   assign c_quo[0]   = '0;
   assign c_den[0]   = s2_den_ff;
   assign c_side[0]  = s2_side_ff;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      fpa_div_cell #(.NB(NB)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (advance),
         .valid_i (c_valid[i]),
         .rem_i   (c_rem[i]),
         .num_i   (c_num[i]),
         .quo_i   (c_quo[i]),
         .den_i   (c_den[i]),
         .side_i  (c_side[i]),
         .valid_o (c_valid[i+1]),
         .rem_o   (c_rem[i+1]),
         .num_o   (c_num[i+1]),
         .quo_o   (c_quo[i+1]),
         .den_o   (c_den[i+1]),
         .side_o  (c_side[i+1])
      );
   end

   // Quotient rounding, sign and saturation.
   localparam logic [NB:0] POS_LIM = (NB+1)'(64'h7FFF_FFFF);
   localparam logic [NB:0] NEG_LIM = (NB+1)'(64'h8000_0000);

   logic [NB:0]    q;
   logic           half_up;
   fpa_side_type   o_side;

   always_comb begin
      half_up = {c_rem[NB], 1'b0} >= {1'b0, c_den[NB]};
      q       = {1'b0, c_quo[NB]} + (NB+1)'(half_up);
      o_side  = c_side[NB];
      if (o_side.is_div) begin
         if (o_side.neg) begin
            if (q > NEG_LIM) begin
               o_side.value  = S32_MIN[31:0];
               o_side.status = ST_OVF;
            end else begin
               o_side.value = 32'(-q[31:0]);
            end
         end else begin
            if (q > POS_LIM) begin
               o_side.value  = S32_MAX[31:0];
               o_side.status = ST_OVF;
            end else begin
               o_side.value = q[31:0];
            end
         end
      end
   end

   // Output register.
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid[NB];
      end
      if (advance) begin
         rsp_data_ff <= {5'b0, o_side.status, o_side.cmp, o_side.value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A true compare never carries a value or a status.
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0 && rsp_tdata[34:33] == ST_OK)
      else $error("compare result carries value or status");

   // Divide by zero always returns zero.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:33] == ST_DZ |-> rsp_tdata[31:0] == 32'd0)
      else $error("divide by zero returned nonzero value");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled pipeline does not take input.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

endmodule

// ===== hdl/fpa_front.sv =====
// Decode stage of the fixed-point ALU: every action but the multiply and the divide, and the
// divider operand preparation. Depends on fpa_pkg.
module fpa_front #(
   parameter int FRAC_BITS = 8
) (
   input  fpa_pkg::fpa_action_type  action,
   input  logic signed [31:0]       operand_a,
   input  logic signed [31:0]       operand_b,
   output fpa_pkg::fpa_side_type    side,
   output logic [32+FRAC_BITS-1:0]  num,
   output logic [31:0]              den
);
   import fpa_pkg::*;

   localparam int NB = 32 + FRAC_BITS;

   logic signed [63:0] a64;
   logic signed [63:0] b64;
   logic [32:0]        sat;
   logic [31:0]        abs_a;

   assign a64   = 64'(operand_a);
   assign b64   = 64'(operand_b);
   assign abs_a = operand_a[31] ? 32'(-operand_a) : operand_a;
   assign den   = operand_b[31] ? 32'(-operand_b) : operand_b;
   assign num   = NB'({abs_a, {FRAC_BITS{1'b0}}});

   // Per-action result selection.
   always_comb begin
      side        = '0;
      side.status = ST_OK;
      sat         = '0;
      case (action)
         ACT_ADD:      sat = fpa_sat(a64 + b64);
         ACT_SUB:      sat = fpa_sat(a64 - b64);
         ACT_INC:      sat = fpa_sat(a64 + 64'sd1);
         ACT_DEC:      sat = fpa_sat(a64 - 64'sd1);
         ACT_FROM_INT: sat = fpa_sat(a64 <<< FRAC_BITS);
         ACT_TO_INT:   sat = {1'b0, 32'(operand_a >>> FRAC_BITS)};
         ACT_MIN:      sat = {1'b0, (operand_a > operand_b) ? operand_b : operand_a};
         ACT_MAX:      sat = {1'b0, (operand_a > operand_b) ? operand_a : operand_b};
         ACT_GT:       side.cmp = operand_a > operand_b;
         ACT_LT:       side.cmp = operand_a < operand_b;
         ACT_GE:       side.cmp = operand_a >= operand_b;
         ACT_LE:       side.cmp = operand_a <= operand_b;
         ACT_EQ:       side.cmp = operand_a == operand_b;
         ACT_NE:       side.cmp = operand_a != operand_b;
         ACT_DIV: begin
            if (operand_b == 32'sd0) begin
               side.status = ST_DZ;
            end else begin
               side.is_div = 1'b1;
               side.neg    = operand_a[31] ^ operand_b[31];
            end
         end
         default: sat = '0;
      endcase
      side.value = sat[31:0];
      if (sat[32]) begin
         side.status = ST_OVF;
      end
   end

endmodule

// ===== hdl/fpa_div_cell.sv =====
// One restoring-division cell: develops one quotient bit per cycle while enable is high and
// hands remainder, numerator, quotient, divisor and side record on. Depends on fpa_pkg.
module fpa_div_cell #(
   parameter int NB = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_i,
   input  logic [31:0]           rem_i,
   input  logic [NB-1:0]         num_i,
   input  logic [NB-1:0]         quo_i,
   input  logic [31:0]           den_i,
   input  fpa_pkg::fpa_side_type side_i,
   output logic                  valid_o,
   output logic [31:0]           rem_o,
   output logic [NB-1:0]         num_o,
   output logic [NB-1:0]         quo_o,
   output logic [31:0]           den_o,
   output fpa_pkg::fpa_side_type side_o
);
   import fpa_pkg::*;

   logic          valid_ff;
   logic [31:0]   rem_ff, rem_in;
   logic [NB-1:0] num_ff, quo_ff, quo_in;
   logic [31:0]   den_ff;
   fpa_side_type  side_ff;
   logic [32:0]   shifted;
   logic [32:0]   diff;

   // Shift in the next numerator bit and try to subtract the divisor.
   always_comb begin
      shifted = {rem_i, num_i[NB-1]};
      diff    = shifted - {1'b0, den_i};
      if (shifted >= {1'b0, den_i}) begin
         rem_in = diff[31:0];
         quo_in = {quo_i[NB-2:0], 1'b1};
      end else begin
         rem_in = shifted[31:0];
         quo_in = {quo_i[NB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
      if (enable) begin
         rem_ff  <= rem_in;
         num_ff  <= {num_i[NB-2:0], 1'b0};
         quo_ff  <= quo_in;
         den_ff  <= den_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign num_o   = num_ff;
   assign quo_o   = quo_ff;
   assign den_o   = den_ff;
   assign side_o  = side_ff;

endmodule
